FILE: rtl/core/hrkm_pkg.sv
// Shared types, constants and key map ROM for the HID report to key matrix converter.
package hrkm_pkg;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_code_1;
        logic [7:0] key_code_2;
        logic [7:0] key_code_3;
        logic [7:0] key_code_4;
        logic [7:0] key_code_5;
        logic [7:0] key_code_6;
    } hrkm_in_t;

    typedef struct packed {
        logic       write_valid;
        logic [6:0] switch_address;
        logic       switch_closed;
        logic       num_lock_led;
        logic       caps_lock_led;
        logic       activity_led;
        logic       last;
    } hrkm_out_t;

    typedef struct packed {
        logic main_valid;
        logic [6:0] main_addr;
        logic mod_valid;
        logic [6:0] mod_addr;
    } key_map_t;

    typedef struct packed {
        logic now;
        logic pressed;
        logic released;
    } key_edge_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_MOD,
        ST_EMIT_MAIN,
        ST_STATUS
    } state_t;

    localparam int         MAX_SLOTS  = 6;
    localparam logic [7:0] CAPS_CODE  = 8'h39;
    localparam logic [7:0] VK_ALT     = 8'h70;
    localparam logic [7:0] VK_CTRL    = 8'h71;
    localparam logic [7:0] VK_SHIFT   = 8'h72;
    localparam logic [7:0] VK_GUI     = 8'h73;
    localparam logic [7:0] MASK_ALT   = 8'h44;
    localparam logic [7:0] MASK_CTRL  = 8'h11;
    localparam logic [7:0] MASK_SHIFT = 8'h22;
    localparam logic [7:0] MASK_GUI   = 8'h88;
    localparam logic [7:0] MAPPED     = 8'h80;

    localparam int LED_NUM  = 0;
    localparam int LED_CAPS = 1;
    localparam int LED_ACT  = 2;

    function automatic logic [7:0] main_rom(input logic [7:0] code);
        logic [7:0] r;
        unique case (code)
            8'h04: r = MAPPED | 8'h10;
            8'h05: r = MAPPED | 8'h74;
            8'h06: r = MAPPED | 8'h03;
            8'h07: r = MAPPED | 8'h12;
            8'h08: r = MAPPED | 8'h22;
            8'h09: r = MAPPED | 8'h13;
            8'h0A: r = MAPPED | 8'h14;
            8'h0B: r = MAPPED | 8'h64;
            8'h0C: r = MAPPED | 8'h52;
            8'h0D: r = MAPPED | 8'h63;
            8'h0E: r = MAPPED | 8'h62;
            8'h0F: r = MAPPED | 8'h61;
            8'h10: r = MAPPED | 8'h72;
            8'h11: r = MAPPED | 8'h73;
            8'h12: r = MAPPED | 8'h51;
            8'h13: r = MAPPED | 8'h50;
            8'h14: r = MAPPED | 8'h20;
            8'h15: r = MAPPED | 8'h23;
            8'h16: r = MAPPED | 8'h11;
            8'h17: r = MAPPED | 8'h24;
            8'h18: r = MAPPED | 8'h53;
            8'h19: r = MAPPED | 8'h04;
            8'h1A: r = MAPPED | 8'h21;
            8'h1B: r = MAPPED | 8'h02;
            8'h1C: r = MAPPED | 8'h54;
            8'h1D: r = MAPPED | 8'h01;
            8'h1E: r = MAPPED | 8'h30;
            8'h1F: r = MAPPED | 8'h31;
            8'h20: r = MAPPED | 8'h32;
            8'h21: r = MAPPED | 8'h33;
            8'h22: r = MAPPED | 8'h34;
            8'h23: r = MAPPED | 8'h44;
            8'h24: r = MAPPED | 8'h43;
            8'h25: r = MAPPED | 8'h42;
            8'h26: r = MAPPED | 8'h41;
            8'h27: r = MAPPED | 8'h40;
            8'h28: r = MAPPED | 8'h60;
            8'h29: r = MAPPED | 8'h70;
            8'h2A: r = MAPPED | 8'h40;
            8'h2B: r = MAPPED | 8'h30;
            8'h2C: r = MAPPED | 8'h70;
            8'h2D: r = MAPPED | 8'h63;
            8'h2E: r = MAPPED | 8'h62;
            8'h30: r = MAPPED | 8'h61;
            8'h33: r = MAPPED | 8'h51;
            8'h34: r = MAPPED | 8'h50;
            8'h36: r = MAPPED | 8'h72;
            8'h37: r = MAPPED | 8'h73;
            8'h38: r = MAPPED | 8'h03;
            8'h39: r = MAPPED | 8'h31;
            8'h46: r = MAPPED | 8'h41;
            8'h4B: r = MAPPED | 8'h32;
            8'h4E: r = MAPPED | 8'h33;
            8'h4F: r = MAPPED | 8'h42;
            8'h50: r = MAPPED | 8'h34;
            8'h51: r = MAPPED | 8'h44;
            8'h52: r = MAPPED | 8'h43;
            8'h54: r = MAPPED | 8'h04;
            8'h56: r = MAPPED | 8'h52;
            8'h57: r = MAPPED | 8'h62;
            8'h58: r = MAPPED | 8'h60;
            8'h59: r = MAPPED | 8'h30;
            8'h5A: r = MAPPED | 8'h31;
            8'h5B: r = MAPPED | 8'h32;
            8'h5C: r = MAPPED | 8'h33;
            8'h5D: r = MAPPED | 8'h34;
            8'h5E: r = MAPPED | 8'h44;
            8'h5F: r = MAPPED | 8'h43;
            8'h60: r = MAPPED | 8'h42;
            8'h61: r = MAPPED | 8'h41;
            8'h62: r = MAPPED | 8'h40;
            8'h70: r = MAPPED | 8'h71;
            8'h71: r = MAPPED | 8'h00;
            8'h72: r = MAPPED | 8'h71;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mod_rom(input logic [7:0] code);
        logic [7:0] r;
        unique case (code)
            8'h29, 8'h2A, 8'h2B, 8'h39, 8'h46, 8'h4B, 8'h4E, 8'h4F,
            8'h50, 8'h51, 8'h52, 8'h70: r = MAPPED | 8'h00;
            8'h2D, 8'h2E, 8'h30, 8'h33, 8'h34, 8'h36, 8'h37, 8'h38,
            8'h54, 8'h56, 8'h57: r = MAPPED | 8'h71;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic key_map_t key_map(input logic [7:0] code);
        key_map_t   m;
        logic [7:0] a;
        logic [7:0] b;
        a = main_rom(code);
        b = mod_rom(code);
        m.main_valid = a[7];
        m.main_addr  = a[6:0];
        m.mod_valid  = b[7];
        m.mod_addr   = b[6:0];
        return m;
    endfunction

endpackage

FILE: rtl/core/hrkm_key_match.sv
// Per-code match unit: pressed state of the scanned code and its change against the last report.
module hrkm_key_match #(
    parameter int IDX_W        = 7,
    parameter int REPORT_SLOTS = 6
) (
    input  hrkm_pkg::hrkm_in_t  report,
    input  logic [IDX_W-1:0]    idx,
    input  logic                prev_bit,
    output hrkm_pkg::key_edge_t key_edge
);

    logic [7:0] code;
    logic [7:0] slots [hrkm_pkg::MAX_SLOTS];
    logic       slot_hit;
    logic       mod_hit;
    logic       now_bit;
    logic [7:0] mb;

    assign code     = 8'(idx);
    assign mb       = report.modifier_bits;
    assign slots[0] = report.key_code_1;
    assign slots[1] = report.key_code_2;
    assign slots[2] = report.key_code_3;
    assign slots[3] = report.key_code_4;
    assign slots[4] = report.key_code_5;
    assign slots[5] = report.key_code_6;

    always_comb begin
        slot_hit = 1'b0;
        for (int s = 0; s < REPORT_SLOTS; s++) begin
            if (slots[s] != 8'h00 && slots[s] == code) begin
                slot_hit = 1'b1;
            end
        end
    end

    assign mod_hit = (code == hrkm_pkg::VK_ALT   && |(mb & hrkm_pkg::MASK_ALT))
                  || (code == hrkm_pkg::VK_CTRL  && |(mb & hrkm_pkg::MASK_CTRL))
                  || (code == hrkm_pkg::VK_SHIFT && |(mb & hrkm_pkg::MASK_SHIFT))
                  || (code == hrkm_pkg::VK_GUI   && |(mb & hrkm_pkg::MASK_GUI));

    assign now_bit           = slot_hit || mod_hit;
    assign key_edge.now      = now_bit;
    assign key_edge.pressed  = now_bit && !prev_bit;
    assign key_edge.released = !now_bit && prev_bit;

endmodule

FILE: rtl/core/hid_report_to_key_matrix.sv
// Top level: scans the key codes of each report and emits crosspoint switch writes.
//
//   channel | dir | ports                          | transfer
//   --------+-----+--------------------------------+---------------------------------
//   s_      | in  | s_valid s_ready s_data         | one boot keyboard report
//   m_      | out | m_valid m_ready m_data         | one switch write or status item
//
// Each report gives W switch writes (up to 28) and one status item; the scan sequencer
// visits one code per cycle through a single match unit while no write is pending, and
// each write holds the sequencer in an emit state until the output register is free.
// s_ready is high only while the sequencer is idle.
// After reset a clearing pass over all KEY_CODES entries zeroes the pressed-key memory; LEDs and
// caps toggle reset at once. s_ready stays low during the pass.
// A stalled m_ready holds the sequencer in its emit state; results wait in the output register.
module hid_report_to_key_matrix #(
    parameter int KEY_CODES    = 128,
    parameter int REPORT_SLOTS = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrkm_pkg::hrkm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrkm_pkg::hrkm_out_t m_data
);

    localparam int             IDX_W    = $clog2(KEY_CODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_CODES - 2);
    localparam logic [IDX_W-1:0] CLR_IDX  = IDX_W'(KEY_CODES - 1);

    hrkm_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    hrkm_pkg::hrkm_in_t  report_reg, report_next;
    logic                caps_toggle_reg, caps_toggle_next;
    logic [2:0]          led_reg, led_next;
    hrkm_pkg::key_map_t  map_reg, map_next;
    logic                closed_reg, closed_next;
    logic                m_valid_reg, m_valid_next;
    hrkm_pkg::hrkm_out_t m_data_reg, m_data_next;

    logic                prev_mem [KEY_CODES];
    logic                prev_q_reg;
    logic                prev_we;
    logic                prev_wdata;

    hrkm_pkg::key_edge_t key_edge;
    hrkm_pkg::key_map_t  map_cur;
    logic                out_free;
    logic [2:0]          led_upd;

    hrkm_key_match #(
        .IDX_W        (IDX_W),
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_match (
        .report   (report_reg),
        .idx      (idx_reg),
        .prev_bit (prev_q_reg),
        .key_edge (key_edge)
    );

    assign map_cur  = hrkm_pkg::key_map(8'(idx_reg));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == hrkm_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // pressed-key memory; read data is ready for the code that the sequencer visits next
    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[idx_reg] <= prev_wdata;
        end
        prev_q_reg <= prev_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= hrkm_pkg::ST_CLEAR;
            idx_reg         <= '0;
            caps_toggle_reg <= 1'b1;
            led_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            caps_toggle_reg <= caps_toggle_next;
            led_reg         <= led_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        report_reg <= report_next;
        map_reg    <= map_next;
        closed_reg <= closed_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        report_next      = report_reg;
        caps_toggle_next = caps_toggle_reg;
        led_next         = led_reg;
        map_next         = map_reg;
        closed_next      = closed_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        led_upd          = led_reg;
        prev_we          = 1'b0;
        prev_wdata       = 1'b0;

        unique case (state_reg)
            hrkm_pkg::ST_CLEAR: begin
                prev_we = 1'b1;
                if (idx_reg == CLR_IDX) begin
                    state_next = hrkm_pkg::ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hrkm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    report_next = s_data;
                    idx_next    = '0;
                    state_next  = hrkm_pkg::ST_SCAN;
                end
            end
            hrkm_pkg::ST_SCAN: begin
                prev_we    = 1'b1;
                prev_wdata = key_edge.now;
                if (key_edge.pressed) begin
                    if (8'(idx_reg) == hrkm_pkg::CAPS_CODE) begin
                        led_upd[hrkm_pkg::LED_CAPS] = caps_toggle_reg;
                        caps_toggle_next            = !caps_toggle_reg;
                    end else begin
                        led_upd[hrkm_pkg::LED_NUM] = 1'b1;
                    end
                    led_upd[hrkm_pkg::LED_ACT] = 1'b1;
                    closed_next                = 1'b1;
                end else if (key_edge.released) begin
                    led_upd[hrkm_pkg::LED_NUM] = 1'b0;
                    led_upd[hrkm_pkg::LED_ACT] = 1'b0;
                    closed_next                = 1'b0;
                end
                led_next = led_upd;
                if ((key_edge.pressed || key_edge.released) && map_cur.main_valid) begin
                    map_next   = map_cur;
                    state_next = map_cur.mod_valid ? hrkm_pkg::ST_EMIT_MOD
                                                   : hrkm_pkg::ST_EMIT_MAIN;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = hrkm_pkg::ST_STATUS;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hrkm_pkg::ST_EMIT_MOD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{write_valid: 1'b1, switch_address: map_reg.mod_addr,
                                     switch_closed: closed_reg,
                                     num_lock_led: led_reg[hrkm_pkg::LED_NUM],
                                     caps_lock_led: led_reg[hrkm_pkg::LED_CAPS],
                                     activity_led: led_reg[hrkm_pkg::LED_ACT],
                                     last: 1'b0};
                    state_next   = hrkm_pkg::ST_EMIT_MAIN;
                end
            end
            hrkm_pkg::ST_EMIT_MAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{write_valid: 1'b1, switch_address: map_reg.main_addr,
                                     switch_closed: closed_reg,
                                     num_lock_led: led_reg[hrkm_pkg::LED_NUM],
                                     caps_lock_led: led_reg[hrkm_pkg::LED_CAPS],
                                     activity_led: led_reg[hrkm_pkg::LED_ACT],
                                     last: 1'b0};
                    if (idx_reg == LAST_IDX) begin
                        state_next = hrkm_pkg::ST_STATUS;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = hrkm_pkg::ST_SCAN;
                    end
                end
            end
            hrkm_pkg::ST_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{write_valid: 1'b0, switch_address: 7'h00,
                                     switch_closed: 1'b0,
                                     num_lock_led: led_reg[hrkm_pkg::LED_NUM],
                                     caps_lock_led: led_reg[hrkm_pkg::LED_CAPS],
                                     activity_led: led_reg[hrkm_pkg::LED_ACT],
                                     last: 1'b1};
                    state_next   = hrkm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hrkm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/hrkm_checker.sv
// Port-level assertions for the HID report to key matrix converter, with its bind.
module hrkm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input hrkm_pkg::hrkm_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a report transfer");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_valid |-> m_data.last)
        else $error("status item without last");

    a_write_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_valid |-> !m_data.last)
        else $error("switch write marked last");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.switch_address == 7'h00 && !m_data.switch_closed)
        else $error("status item carries a switch address");

endmodule

bind hid_report_to_key_matrix hrkm_checker u_hrkm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/tb_top.sv
// Self-checking testbench for hid_report_to_key_matrix with a local predictor.
module tb_top;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 200;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    hrkm_pkg::hrkm_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    hrkm_pkg::hrkm_out_t m_data;

    hid_report_to_key_matrix u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [7:0]          map_main [0:127];
    logic [7:0]          map_mod  [0:127];
    logic                key_held [0:127];
    logic                caps_next;
    logic [2:0]          led_bits;
    hrkm_pkg::hrkm_out_t expected_items [$];
    hrkm_pkg::hrkm_out_t want;
    hrkm_pkg::hrkm_in_t  last_report;

    bit sender_idles = 1'b0;
    bit sink_idles   = 1'b0;
    int error_count  = 0;
    int reports_sent = 0;
    int writes_seen  = 0;
    int status_seen  = 0;
    int idle_cycles  = 0;

    function automatic void map_key(logic [7:0] code, logic [6:0] main_addr);
        map_main[code[6:0]] = {1'b1, main_addr};
    endfunction

    function automatic void map_key_mod(logic [7:0] code, logic [6:0] mod_addr);
        map_mod[code[6:0]] = {1'b1, mod_addr};
    endfunction

    task automatic load_key_map();
        for (int i = 0; i < 128; i++) begin
            map_main[i] = '0;
            map_mod[i]  = '0;
        end
        map_key(8'h04, 7'h10); map_key(8'h05, 7'h74); map_key(8'h06, 7'h03);
        map_key(8'h07, 7'h12); map_key(8'h08, 7'h22); map_key(8'h09, 7'h13);
        map_key(8'h0A, 7'h14); map_key(8'h0B, 7'h64); map_key(8'h0C, 7'h52);
        map_key(8'h0D, 7'h63); map_key(8'h0E, 7'h62); map_key(8'h0F, 7'h61);
        map_key(8'h10, 7'h72); map_key(8'h11, 7'h73); map_key(8'h12, 7'h51);
        map_key(8'h13, 7'h50); map_key(8'h14, 7'h20); map_key(8'h15, 7'h23);
        map_key(8'h16, 7'h11); map_key(8'h17, 7'h24); map_key(8'h18, 7'h53);
        map_key(8'h19, 7'h04); map_key(8'h1A, 7'h21); map_key(8'h1B, 7'h02);
        map_key(8'h1C, 7'h54); map_key(8'h1D, 7'h01); map_key(8'h1E, 7'h30);
        map_key(8'h1F, 7'h31); map_key(8'h20, 7'h32); map_key(8'h21, 7'h33);
        map_key(8'h22, 7'h34); map_key(8'h23, 7'h44); map_key(8'h24, 7'h43);
        map_key(8'h25, 7'h42); map_key(8'h26, 7'h41); map_key(8'h27, 7'h40);
        map_key(8'h28, 7'h60); map_key(8'h29, 7'h70); map_key(8'h2A, 7'h40);
        map_key(8'h2B, 7'h30); map_key(8'h2C, 7'h70); map_key(8'h2D, 7'h63);
        map_key(8'h2E, 7'h62); map_key(8'h30, 7'h61); map_key(8'h33, 7'h51);
        map_key(8'h34, 7'h50); map_key(8'h36, 7'h72); map_key(8'h37, 7'h73);
        map_key(8'h38, 7'h03); map_key(8'h39, 7'h31); map_key(8'h46, 7'h41);
        map_key(8'h4B, 7'h32); map_key(8'h4E, 7'h33); map_key(8'h4F, 7'h42);
        map_key(8'h50, 7'h34); map_key(8'h51, 7'h44); map_key(8'h52, 7'h43);
        map_key(8'h54, 7'h04); map_key(8'h56, 7'h52); map_key(8'h57, 7'h62);
        map_key(8'h58, 7'h60); map_key(8'h59, 7'h30); map_key(8'h5A, 7'h31);
        map_key(8'h5B, 7'h32); map_key(8'h5C, 7'h33); map_key(8'h5D, 7'h34);
        map_key(8'h5E, 7'h44); map_key(8'h5F, 7'h43); map_key(8'h60, 7'h42);
        map_key(8'h61, 7'h41); map_key(8'h62, 7'h40); map_key(8'h70, 7'h71);
        map_key(8'h71, 7'h00); map_key(8'h72, 7'h71);
        map_key_mod(8'h29, 7'h00); map_key_mod(8'h2A, 7'h00); map_key_mod(8'h2B, 7'h00);
        map_key_mod(8'h2D, 7'h71); map_key_mod(8'h2E, 7'h71); map_key_mod(8'h30, 7'h71);
        map_key_mod(8'h33, 7'h71); map_key_mod(8'h34, 7'h71); map_key_mod(8'h36, 7'h71);
        map_key_mod(8'h37, 7'h71); map_key_mod(8'h38, 7'h71); map_key_mod(8'h39, 7'h00);
        map_key_mod(8'h46, 7'h00); map_key_mod(8'h4B, 7'h00); map_key_mod(8'h4E, 7'h00);
        map_key_mod(8'h4F, 7'h00); map_key_mod(8'h50, 7'h00); map_key_mod(8'h51, 7'h00);
        map_key_mod(8'h52, 7'h00); map_key_mod(8'h54, 7'h71); map_key_mod(8'h56, 7'h71);
        map_key_mod(8'h57, 7'h71); map_key_mod(8'h70, 7'h00);
        for (int i = 0; i < 128; i++) key_held[i] = 1'b0;
        caps_next = 1'b1;
        led_bits  = '0;
    endtask

    function automatic void push_item(logic wv, logic [6:0] addr, logic closed, logic fin);
        hrkm_pkg::hrkm_out_t o;
        o.write_valid    = wv;
        o.switch_address = addr;
        o.switch_closed  = closed;
        o.num_lock_led   = led_bits[hrkm_pkg::LED_NUM];
        o.caps_lock_led  = led_bits[hrkm_pkg::LED_CAPS];
        o.activity_led   = led_bits[hrkm_pkg::LED_ACT];
        o.last           = fin;
        expected_items.push_back(o);
    endfunction

    function automatic void push_switch_writes(int code, logic closed);
        if (map_main[code][7]) begin
            if (map_mod[code][7]) push_item(1'b1, map_mod[code][6:0], closed, 1'b0);
            push_item(1'b1, map_main[code][6:0], closed, 1'b0);
        end
    endfunction

    function automatic void predict_key_changes(hrkm_pkg::hrkm_in_t r);
        logic       now_set [0:127];
        logic [7:0] codes   [6];
        for (int i = 0; i < 128; i++) now_set[i] = 1'b0;
        if ((r.modifier_bits & hrkm_pkg::MASK_ALT) != 0)
            now_set[hrkm_pkg::VK_ALT[6:0]] = 1'b1;
        if ((r.modifier_bits & hrkm_pkg::MASK_CTRL) != 0)
            now_set[hrkm_pkg::VK_CTRL[6:0]] = 1'b1;
        if ((r.modifier_bits & hrkm_pkg::MASK_SHIFT) != 0)
            now_set[hrkm_pkg::VK_SHIFT[6:0]] = 1'b1;
        if ((r.modifier_bits & hrkm_pkg::MASK_GUI) != 0)
            now_set[hrkm_pkg::VK_GUI[6:0]] = 1'b1;
        codes = '{r.key_code_1, r.key_code_2, r.key_code_3,
                  r.key_code_4, r.key_code_5, r.key_code_6};
        foreach (codes[s])
            if (codes[s] != 0 && !codes[s][7]) now_set[codes[s][6:0]] = 1'b1;
        // top code is never scanned
        for (int i = 0; i < 127; i++) begin
            if (now_set[i] && !key_held[i]) begin
                if (i == hrkm_pkg::CAPS_CODE) begin
                    led_bits[hrkm_pkg::LED_CAPS] = caps_next;
                    caps_next = ~caps_next;
                end else begin
                    led_bits[hrkm_pkg::LED_NUM] = 1'b1;
                end
                led_bits[hrkm_pkg::LED_ACT] = 1'b1;
                push_switch_writes(i, 1'b1);
            end else if (!now_set[i] && key_held[i]) begin
                led_bits[hrkm_pkg::LED_NUM] = 1'b0;
                led_bits[hrkm_pkg::LED_ACT] = 1'b0;
                push_switch_writes(i, 1'b0);
            end
            key_held[i] = now_set[i];
        end
        push_item(1'b0, 7'h00, 1'b0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [6:0] exp_v, logic [6:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_items.size() == 0) begin
                $error("result transfer with nothing expected: %0h", m_data);
                error_count++;
            end else begin
                want = expected_items.pop_front();
                check_field("write_valid", want.write_valid, m_data.write_valid);
                check_field("switch_address", want.switch_address, m_data.switch_address);
                check_field("switch_closed", want.switch_closed, m_data.switch_closed);
                check_field("num_lock_led", want.num_lock_led, m_data.num_lock_led);
                check_field("caps_lock_led", want.caps_lock_led, m_data.caps_lock_led);
                check_field("activity_led", want.activity_led, m_data.activity_led);
                check_field("last", want.last, m_data.last);
            end
            if (m_data.write_valid) writes_seen++;
            else status_seen++;
        end
    end

    always @(posedge aclk) begin
        m_ready <= sink_idles ? ($urandom_range(99) >= 35) : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_report(hrkm_pkg::hrkm_in_t r);
        do @(posedge aclk); while (sender_idles && $urandom_range(99) < 35);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_key_changes(r);
        reports_sent++;
        last_report = r;
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_items.size() != 0) @(posedge aclk);
    endtask

    function automatic hrkm_pkg::hrkm_in_t mk(logic [7:0] m, logic [7:0] a, logic [7:0] b,
                                              logic [7:0] c, logic [7:0] d, logic [7:0] e,
                                              logic [7:0] f);
        return hrkm_pkg::hrkm_in_t'{m, a, b, c, d, e, f};
    endfunction

    function automatic logic [7:0] pick_code();
        int p;
        p = $urandom_range(99);
        if (p < 70) return 8'($urandom_range(8'h04, 8'h65));
        if (p < 80) return hrkm_pkg::CAPS_CODE;
        if (p < 88) return 8'($urandom_range(8'h66, 8'h7F));
        if (p < 94) return 8'($urandom_range(1, 3));
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // mostly typing-like edits of the last report, some fresh ones, some noise
    function automatic hrkm_pkg::hrkm_in_t next_report();
        hrkm_pkg::hrkm_in_t r;
        logic [7:0]         slot [6];
        int                 p;
        p = $urandom_range(99);
        if (p < 10) return hrkm_pkg::hrkm_in_t'($urandom_range(32'hFFFF_FFFF) ^
                                                {$urandom_range(32'hFFFF_FFFF), 24'h0});
        r = last_report;
        slot = '{r.key_code_1, r.key_code_2, r.key_code_3,
                 r.key_code_4, r.key_code_5, r.key_code_6};
        if (p < 70) begin
            if ($urandom_range(3) == 0) r.modifier_bits[$urandom_range(7)] ^= 1'b1;
            repeat ($urandom_range(1, 2))
                slot[$urandom_range(5)] = ($urandom_range(2) == 0) ? 8'h00 : pick_code();
        end else begin
            r.modifier_bits = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
            foreach (slot[s]) slot[s] = $urandom_range(1) ? 8'h00 : pick_code();
        end
        r.key_code_1 = slot[0]; r.key_code_2 = slot[1]; r.key_code_3 = slot[2];
        r.key_code_4 = slot[3]; r.key_code_5 = slot[4]; r.key_code_6 = slot[5];
        return r;
    endfunction

    task automatic test_directed();
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // caps lock toggles its LED on each press
        send_report(mk(8'h00, hrkm_pkg::CAPS_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, hrkm_pkg::CAPS_CODE));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h03, 8'h47, 8'h65, 8'h01, 8'h02, 8'h7E));
        send_report(mk(8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_report(mk(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04));
        send_report(mk(8'hFF, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h30));
        send_report(mk(8'h00, 8'h33, 8'h34, 8'h36, 8'h37, 8'h38, 8'h46));
        send_report(mk(8'hFF, 8'h4B, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52));
        send_report(mk(8'hAA, 8'h54, 8'h56, 8'h57, 8'h62, 8'h05, 8'h1D));
        send_report(mk(8'h55, 8'h62, 8'hC3, 8'h7F, 8'h00, 8'h39, 8'h28));
        send_report(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_random_no_idle(int count);
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        repeat (count) send_report(next_report());
    endtask

    task automatic test_random_idle(int count);
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        repeat (count) send_report(next_report());
    endtask

    task automatic test_drained_restart(int count);
        wait_for_results();
        repeat (count) send_report(next_report());
    endtask

    initial begin
        load_key_map();
        last_report = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_idle(180);
        test_drained_restart(20);
        test_random_no_idle(120);
        test_random_idle(180);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("tb_top: %0d reports, %0d switch writes, %0d status items checked",
                 reports_sent, writes_seen, status_seen);
        $display("tb_top: directed edge cases, random typing with and without idling");
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
